// File: rtl/itbd_pkg.sv
// Shared types, character codes and a helper function for the integer to base digits block.
// Used by itbd_ctrl, itbd_dp and the integer_to_base_digits top level.
`default_nettype none

package itbd_pkg;

	// Fixed widths of the word fields.
	localparam int ValueW = 32;
	localparam int BaseW  = 6;
	localparam int WidthW = 6;
	localparam int CharW  = 8;
	localparam int LenW   = 6;

	// Dividend bits consumed per cycle by the divider.
	localparam int StepsPerCycle = 8;

	// Radix limits.
	localparam logic [BaseW-1:0] BaseMin = 6'd2;
	localparam logic [BaseW-1:0] BaseMax = 6'd36;

	// ASCII codes used in the text.
	localparam logic [CharW-1:0] CharZero  = 8'h30;
	localparam logic [CharW-1:0] CharA     = 8'h61;
	localparam logic [CharW-1:0] CharMinus = 8'h2D;

	// Largest digit value written as a decimal numeral.
	localparam logic [BaseW-1:0] DigitNineVal = 6'd9;
	localparam logic [CharW-1:0] LetterOffset = 8'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic digit_done;
		logic calc_len;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic quot_zero;
		logic ndig_full;
		logic last_char;
	} sts_t;

	// Maps a digit value to its ASCII character, letters from ten up.
	function automatic logic [CharW-1:0] digit_char(input logic [BaseW-1:0] d);
		logic [CharW-1:0] dw;
		dw = CharW'(d);
		if (d > DigitNineVal) begin
			return CharA + dw - LetterOffset;
		end
		return CharZero + dw;
	endfunction

endpackage

`default_nettype wire

// File: rtl/itbd_ctrl.sv
// Controller state machine for the integer to base digits block.
// Sequences load, digit division, length calculation and character output; uses itbd_pkg.
`default_nettype none

module itbd_ctrl #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire itbd_pkg::sts_t sts,
	output itbd_pkg::cmd_t     cmd
);

	localparam int Passes = (VALUE_BITS + itbd_pkg::StepsPerCycle - 1) / itbd_pkg::StepsPerCycle;
	localparam int PassW  = (Passes > 1) ? $clog2(Passes) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_nx;
	logic [PassW-1:0] pass_q;
	logic             last_pass;
	logic             out_valid_q;
	logic             out_free;

	assign last_pass = (pass_q == PassW'(Passes - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode and next state.
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_pass) begin
					cmd.digit_done = 1'b1;
					if (sts.quot_zero || sts.ndig_full) begin
						state_nx = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				cmd.calc_len = 1'b1;
				state_nx     = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_char) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State, pass counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load || cmd.digit_done) begin
				pass_q <= '0;
			end else if (cmd.div_step) begin
				pass_q <= pass_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/itbd_dp.sv
// Datapath for the integer to base digits block: radix divider, digit stack,
// length counters and the output word register; uses itbd_pkg.
`default_nettype none

module itbd_dp #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          opcode,
	input  wire logic [itbd_pkg::ValueW-1:0]   value,
	input  wire logic [itbd_pkg::BaseW-1:0]    base,
	input  wire logic [itbd_pkg::WidthW-1:0]   field_width,
	input  wire itbd_pkg::cmd_t                cmd,
	output itbd_pkg::sts_t                     sts,
	output logic [itbd_pkg::CharW-1:0]         text_char,
	output logic                               last,
	output logic [itbd_pkg::LenW-1:0]          total_length
);

	localparam int Steps    = itbd_pkg::StepsPerCycle;
	localparam int Passes   = (VALUE_BITS + Steps - 1) / Steps;
	localparam int PW       = Passes * Steps;
	localparam int MaxChars = VALUE_BITS + 1;
	localparam int CW       = $clog2(MaxChars + 1);
	localparam int BW       = itbd_pkg::BaseW;

	logic [VALUE_BITS-1:0] val_ext;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_abs;
	logic [BW-1:0]         base_cl;
	logic [CW-1:0]         width_sat;

	logic [PW-1:0] div_q;
	logic [BW-1:0] rem_q;
	logic [BW-1:0] base_q;
	logic          neg_q;
	logic [CW-1:0] width_q;
	logic [CW-1:0] ndig_q;
	logic [CW-1:0] pad_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] total_q;
	logic [BW-1:0] stk_q [VALUE_BITS];

	logic [PW-1:0] step_d;
	logic [BW:0]   step_r;
	logic [BW:0]   step_t;
	logic [BW-1:0] rem_nx;
	logic [PW-1:0] div_nx;
	logic [CW-1:0] sum_len;
	logic [CW-1:0] char_sel_dummy;

	logic [itbd_pkg::CharW-1:0] text_char_q;
	logic                       last_q;
	logic [CW-1:0]              total_length_q;
	logic [itbd_pkg::CharW-1:0] char_nx;

	// Keep only the low VALUE_BITS of the input word, zero extended when wider.
	generate
		if (VALUE_BITS <= itbd_pkg::ValueW) begin : g_trunc
			assign val_ext = value[VALUE_BITS-1:0];
		end else begin : g_ext
			assign val_ext = {{(VALUE_BITS - itbd_pkg::ValueW){1'b0}}, value};
		end
	endgenerate

	// Sign handling, radix clamp and width saturation at load.
	assign neg_in    = opcode && val_ext[VALUE_BITS-1];
	assign mag_abs   = neg_in ? (~val_ext + 1'b1) : val_ext;
	assign base_cl   = (base < itbd_pkg::BaseMin) ? itbd_pkg::BaseMin :
	                   (base > itbd_pkg::BaseMax) ? itbd_pkg::BaseMax : base;
	assign width_sat = (32'(field_width) > 32'(MaxChars)) ? CW'(MaxChars) : CW'(field_width);

	// Restoring division, several quotient bits per cycle on a narrow remainder.
	always_comb begin
		step_d = div_q;
		step_r = {1'b0, rem_q};
		step_t = '0;
		for (int i = 0; i < Steps; i++) begin
			step_t = {step_r[BW-1:0], step_d[PW-1]};
			step_d = {step_d[PW-2:0], 1'b0};
			if (step_t >= {1'b0, base_q}) begin
				step_t    = step_t - {1'b0, base_q};
				step_d[0] = 1'b1;
			end
			step_r = step_t;
		end
		rem_nx = step_r[BW-1:0];
		div_nx = step_d;
	end

	assign sum_len        = CW'(neg_q) + ndig_q;
	assign char_sel_dummy = pad_q;

	// Next character: sign first, then zero padding, then digits from the stack top.
	always_comb begin
		if (neg_q) begin
			char_nx = itbd_pkg::CharMinus;
		end else if (char_sel_dummy != '0) begin
			char_nx = itbd_pkg::CharZero;
		end else begin
			char_nx = itbd_pkg::digit_char(stk_q[0]);
		end
	end

	assign sts.quot_zero = (div_nx == '0);
	assign sts.ndig_full = (ndig_q == CW'(VALUE_BITS - 1));
	assign sts.last_char = (left_q == CW'(1));

	// Divider, counters and digit stack.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q   <= PW'(mag_abs);
			rem_q   <= '0;
			base_q  <= base_cl;
			neg_q   <= neg_in;
			width_q <= width_sat;
			ndig_q  <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_nx;
			if (cmd.digit_done) begin
				rem_q  <= '0;
				ndig_q <= ndig_q + 1'b1;
			end else begin
				rem_q <= rem_nx;
			end
		end
		if (cmd.calc_len) begin
			if (width_q > sum_len) begin
				total_q <= width_q;
				left_q  <= width_q;
				pad_q   <= width_q - sum_len;
			end else begin
				total_q <= sum_len;
				left_q  <= sum_len;
				pad_q   <= '0;
			end
		end
		if (cmd.emit) begin
			left_q <= left_q - 1'b1;
			if (neg_q) begin
				neg_q <= 1'b0;
			end else if (pad_q != '0) begin
				pad_q <= pad_q - 1'b1;
			end
		end
		// Push a finished digit, or pop one once it is sent.
		if (cmd.digit_done) begin
			stk_q[0] <= rem_nx;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (cmd.emit && !neg_q && (pad_q == '0)) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
			stk_q[VALUE_BITS-1] <= '0;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			text_char_q    <= char_nx;
			last_q         <= (left_q == CW'(1));
			total_length_q <= total_q;
		end
	end

	assign text_char    = text_char_q;
	assign last         = last_q;
	assign total_length = itbd_pkg::LenW'(total_length_q);

endmodule

`default_nettype wire

// File: rtl/integer_to_base_digits.sv
// Integer to ASCII text in radix 2 to 36, one character per output word.
// Top level: joins itbd_ctrl and itbd_dp; uses itbd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one word: opcode, value, base and
//   field_width. Output channel (out_valid / out_stall) gives one word per
//   character, most significant first, with last set on the final character
//   and total_length repeated on each one.
//   One conversion at a time: in_stall is high from the cycle after a word is
//   taken until the final character has entered the output register.
//   Steps: a load, then the digits one at a time in the shared radix divider
//   (8 dividend bits per cycle), a length step, then the characters in order,
//   one per output word, each sent once the output register is free.
//   The output register holds a word while out_stall is high; the block waits
//   and nothing is lost. The next input word can be taken while the final
//   character still waits in the output register.
//   Reset (arst_n low) returns the controller to idle and drops out_valid.
`default_nettype none

module integer_to_base_digits #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        opcode,
	input  wire logic [itbd_pkg::ValueW-1:0] value,
	input  wire logic [itbd_pkg::BaseW-1:0]  base,
	input  wire logic [itbd_pkg::WidthW-1:0] field_width,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [itbd_pkg::CharW-1:0]       text_char,
	output logic                             last,
	output logic [itbd_pkg::LenW-1:0]        total_length
);

	itbd_pkg::cmd_t cmd;
	itbd_pkg::sts_t sts;

	// Sequencer.
	itbd_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Divider, digit stack and output word.
	itbd_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.opcode      (opcode),
		.value       (value),
		.base        (base),
		.field_width (field_width),
		.cmd         (cmd),
		.sts         (sts),
		.text_char   (text_char),
		.last        (last),
		.total_length(total_length)
	);

endmodule

`default_nettype wire
